>>> hw/rtl/psu_pkg.sv
// Shared constants, types and helper functions of the PNG scanline unfilter.
// Used by the channel interfaces and by the front end, queue, back end and top.
package psu_pkg;

    localparam int MAX_ROW_BYTES   = 4096;
    localparam int MAX_PIXEL_BYTES = 8;
    localparam int HIST_DEPTH      = 8;
    localparam int FIFO_DEPTH      = 4;

    localparam int BYTE_W     = 8;
    localparam int RB_W       = 13;
    localparam int BPP_W      = 4;
    localparam int COL_W      = $clog2(MAX_ROW_BYTES);
    localparam int HIST_W     = $clog2(HIST_DEPTH);
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;
    localparam int FILT_W     = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BPP       = CFG_IDX_W'(1);

    // Filter classes carried from front to back.
    localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
    localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
    localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
    localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
    localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;
    localparam logic [FILT_W-1:0] FILT_BAD   = 3'd5;

    localparam logic [RB_W-1:0]  RB_MAX  = RB_W'(MAX_ROW_BYTES);
    localparam logic [BPP_W-1:0] BPP_MAX = BPP_W'(MAX_PIXEL_BYTES);

    // One classified data byte.
    typedef struct packed {
        logic [BYTE_W-1:0] x;
        logic [COL_W-1:0]  col;
        logic [FILT_W-1:0] filt;
        logic              first_row;
        logic              last;
        logic              has_left;
        logic [HIST_W-1:0] left_idx;
    } t_item;

    function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b,
                                                input logic [BYTE_W-1:0] c);
        logic signed [BYTE_W+1:0] p;
        logic signed [BYTE_W+1:0] pa;
        logic signed [BYTE_W+1:0] pb;
        logic signed [BYTE_W+1:0] pc;
        logic [BYTE_W-1:0]        res;
        p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
        pa = p - $signed({2'b00, a});
        pb = p - $signed({2'b00, b});
        pc = p - $signed({2'b00, c});
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/psu_channels.sv
// Handshake channel interfaces of the PNG scanline unfilter: input stream,
// result stream and configuration writes. Depends on psu_pkg.
interface psu_in_if import psu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              image_start;
    modport source (output valid, output in_byte, output image_start, input ready);
    modport sink   (input valid, input in_byte, input image_start, output ready);
endinterface

interface psu_out_if import psu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              row_end;
    logic              bad_filter;
    modport source (output valid, output out_byte, output row_end, output bad_filter,
                    input ready);
    modport sink   (input valid, input out_byte, input row_end, input bad_filter,
                    output ready);
endinterface

interface psu_cfg_if import psu_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/psu_ram.sv
// Generic single-clock RAM, one write port and one read port with registered
// read data. No dependencies.
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/psu_front.sv
// Front end: configuration registers, filter type bytes, column tracking and
// classification of data bytes into queue items. Depends on psu_pkg.
module psu_front import psu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psu_in_if.sink      i_in,
    psu_cfg_if.sink     i_cfg,
    input  logic        i_full,
    output logic        o_push,
    output t_item       o_item
);

    logic [RB_W-1:0]   r_row_bytes;
    logic [BPP_W-1:0]  r_bpp;
    logic [COL_W-1:0]  r_col;
    logic [FILT_W-1:0] r_filt;
    logic              r_await;
    logic              r_first;

    logic [RB_W-1:0]   rb_eff;
    logic [BPP_W-1:0]  bpp_eff;
    logic              accept;
    logic              is_type;
    logic              last;
    logic [FILT_W-1:0] n_filt;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign accept      = i_in.valid && i_in.ready;
    assign is_type     = i_in.image_start || r_await;

    always_comb begin
        rb_eff = r_row_bytes;
        if (r_row_bytes == '0) rb_eff = RB_W'(1);
        if (r_row_bytes > RB_MAX) rb_eff = RB_MAX;
        bpp_eff = r_bpp;
        if (r_bpp == '0) bpp_eff = BPP_W'(1);
        if (r_bpp > BPP_MAX) bpp_eff = BPP_MAX;
    end

    assign last = ({1'b0, r_col} + RB_W'(1)) >= rb_eff;

    // Any type code above Paeth is carried as a single bad class.
    assign n_filt = (i_in.in_byte > BYTE_W'(FILT_PAETH)) ? FILT_BAD
                                                         : i_in.in_byte[FILT_W-1:0];

    assign o_push           = accept && !is_type;
    assign o_item.x         = i_in.in_byte;
    assign o_item.col       = r_col;
    assign o_item.filt      = r_filt;
    assign o_item.first_row = r_first;
    assign o_item.last      = last;
    assign o_item.has_left  = {{(COL_W-BPP_W){1'b0}}, bpp_eff} <= r_col;
    assign o_item.left_idx  = r_col[HIST_W-1:0] - bpp_eff[HIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= RB_W'(1);
            r_bpp       <= BPP_W'(1);
            r_col       <= '0;
            r_filt      <= FILT_NONE;
            r_await     <= 1'b1;
            r_first     <= 1'b1;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_ROW_BYTES) begin
                    r_row_bytes <= i_cfg.data[RB_W-1:0];
                end else if (i_cfg.index == REG_BPP) begin
                    r_bpp <= i_cfg.data[BPP_W-1:0];
                end
            end
            if (accept) begin
                if (is_type) begin
                    if (i_in.image_start) r_first <= 1'b1;
                    r_filt  <= n_filt;
                    r_col   <= '0;
                    r_await <= 1'b0;
                end else if (last) begin
                    r_col   <= '0;
                    r_await <= 1'b1;
                    r_first <= 1'b0;
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

endmodule

>>> hw/rtl/psu_fifo.sv
// Short item queue between the front end and the reconstruction back end.
// Depends on psu_pkg.
module psu_fifo import psu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = r_count == (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (FIFO_AW+1)'(1);
            end
        end
    end

endmodule

>>> hw/rtl/psu_back.sv
// Back end: prior-row RAM read, neighbor history, filter reconstruction and
// the output register. Depends on psu_pkg, psu_ram and the channel interfaces.
module psu_back import psu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_item  i_item,
    output logic   o_pop,
    psu_out_if.source o_out
);

    t_item             r_s1;
    logic              r_s1_v;
    logic              r_byp;
    logic [BYTE_W-1:0] r_byp_data;
    logic [BYTE_W-1:0] r_left [HIST_DEPTH];
    logic [BYTE_W-1:0] r_upl  [HIST_DEPTH];
    logic              r_o_v;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_end;
    logic              r_o_bad;

    logic              s1_move;
    logic              load;
    logic [BYTE_W-1:0] ram_q;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W:0]   avg_sum;
    logic [BYTE_W-1:0] y;

    assign s1_move = r_s1_v && (!r_o_v || o_out.ready);
    assign load    = i_valid && (!r_s1_v || s1_move);
    assign o_pop   = load;

    psu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_prior_row (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1.col),
        .i_wdata (y),
        .i_re    (load),
        .i_raddr (i_item.col),
        .o_rdata (ram_q)
    );

    // A one-byte row reads the column that is being written in the same cycle,
    // so that byte is forwarded past the RAM.
    always_comb begin
        b = '0;
        if (!r_s1.first_row) b = r_byp ? r_byp_data : ram_q;
        a = r_s1.has_left ? r_left[r_s1.left_idx] : '0;
        c = (r_s1.has_left && !r_s1.first_row) ? r_upl[r_s1.left_idx] : '0;
        avg_sum = {1'b0, a} + {1'b0, b};
        unique case (r_s1.filt)
            FILT_NONE:  y = r_s1.x;
            FILT_SUB:   y = r_s1.x + a;
            FILT_UP:    y = r_s1.x + b;
            FILT_AVG:   y = r_s1.x + avg_sum[BYTE_W:1];
            FILT_PAETH: y = r_s1.x + paeth(a, b, c);
            default:    y = r_s1.x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1       <= i_item;
            r_byp      <= s1_move && (r_s1.col == i_item.col);
            r_byp_data <= y;
        end
        if (s1_move) begin
            r_left[r_s1.col[HIST_W-1:0]] <= y;
            r_upl[r_s1.col[HIST_W-1:0]]  <= b;
            r_o_byte <= y;
            r_o_end  <= r_s1.last;
            r_o_bad  <= r_s1.filt == FILT_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (load) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_o_v <= 1'b1;
            end else if (o_out.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.out_byte   = r_o_byte;
    assign o_out.row_end    = r_o_end;
    assign o_out.bad_filter = r_o_bad;

endmodule

>>> hw/rtl/png_scanline_unfilter_top.sv
// PNG scanline unfilter: takes one decompressed byte per cycle while the
// queue is not full and returns one reconstructed byte per data byte. The
// filter type byte of each row is consumed and gives no result. Sustained
// rate is one byte per clock in both directions while neither side stalls;
// an accepted data byte passes through the queue, the back-end stage
// register and the output register. The previous row is kept in a
// 4096-byte RAM that is read as a byte enters the back end and written as it
// leaves for the output register; a four-entry queue lets input and output
// stall independently. The RAM needs no clearing after reset. Configure
// row_bytes (index 0) and bytes_per_pixel (index 1) only while no bytes are
// in flight. Depends on psu_pkg, psu_channels, psu_front, psu_fifo, psu_back.
module png_scanline_unfilter_top import psu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psu_in_if.sink    i_in,
    psu_cfg_if.sink   i_cfg,
    psu_out_if.source o_out
);

    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_item push_item;
    t_item q_item;

    psu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_item  (push_item)
    );

    psu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    psu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> sim/png_scanline_unfilter_top_tb.sv
// Self-checking testbench for png_scanline_unfilter_top: a directed table followed by
// random images, checked against an in-bench scanline reconstruction predictor.
// Depends on psu_pkg, psu_channels and the unfilter RTL.
module png_scanline_unfilter_top_tb;
    import psu_pkg::*;

    localparam int SETTLE       = 8;
    localparam int STALL_CYCLES = 200;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1060;
    localparam int PLAN_LEN     = 36;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic              row_end;
        logic              bad_filter;
    } t_pixel_out;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [BYTE_W-1:0]     dat;
        logic                  st;
        logic                  typed;
        t_pixel_out            want;
    } t_plan_row;

    // Directed rows. Only results that are obvious at a glance are typed in.
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{1'b0, REG_ROW_BYTES, 13'd0,  BYTE_W'(FILT_NONE),  1'b1, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'hFF,               1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
        '{1'b0, REG_ROW_BYTES, 13'd0,  BYTE_W'(FILT_BAD),   1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h80,               1'b0, 1'b1, '{8'h80, 1'b1, 1'b1}},
        '{1'b1, REG_ROW_BYTES, 13'd3,  8'h00,               1'b0, 1'b0, '0},
        '{1'b1, REG_BPP,       13'd2,  8'h00,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  BYTE_W'(FILT_SUB),   1'b1, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h10,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'hF0,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h20,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  BYTE_W'(FILT_AVG),   1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'hFF,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h01,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h7F,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  BYTE_W'(FILT_PAETH), 1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h00,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'hFF,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h80,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  BYTE_W'(FILT_UP),    1'b1, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h33,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  BYTE_W'(FILT_PAETH), 1'b1, 1'b0, '0},
        '{1'b1, REG_ROW_BYTES, 13'd0,  8'h00,               1'b0, 1'b0, '0},
        '{1'b1, REG_BPP,       13'd0,  8'h00,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  BYTE_W'(FILT_NONE),  1'b1, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'hAB,               1'b0, 1'b1, '{8'hAB, 1'b1, 1'b0}},
        '{1'b1, REG_ROW_BYTES, 13'd4,  8'h00,               1'b0, 1'b0, '0},
        '{1'b1, REG_BPP,       13'd15, 8'h00,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  BYTE_W'(FILT_SUB),   1'b1, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h01,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h02,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h03,               1'b0, 1'b0, '0},
        '{1'b1, REG_ROW_BYTES, 13'd2,  8'h00,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h05,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  BYTE_W'(FILT_UP),    1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h10,               1'b0, 1'b0, '0},
        '{1'b0, REG_ROW_BYTES, 13'd0,  8'h20,               1'b0, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    psu_in_if  in_ch ();
    psu_cfg_if cfg_ch ();
    psu_out_if out_ch ();

    png_scanline_unfilter_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #5 clk = ~clk;

    // Predictor state, mirroring the block after reset.
    logic [RB_W-1:0]   rb_reg      = RB_W'(1);
    logic [BPP_W-1:0]  bpp_reg     = BPP_W'(1);
    logic [BYTE_W-1:0] prev_row [MAX_ROW_BYTES];
    bit                prev_set [MAX_ROW_BYTES];
    logic [BYTE_W-1:0] left_hist [HIST_DEPTH] = '{default: '0};
    logic [BYTE_W-1:0] ul_hist [HIST_DEPTH]   = '{default: '0};
    int unsigned       col_pos     = 0;
    logic [BYTE_W-1:0] filt_type   = '0;
    bit                want_filter = 1'b1;
    bit                first_row   = 1'b1;

    t_pixel_out pending_bytes [$];
    int         fail_count   = 0;
    int         random_sent  = 0;
    int         quiet_cycles = 0;
    int         hold_left    = 0;
    bit         hold_done    = 1'b0;
    bit         hold_req     = 1'b0;
    bit         steady       = 1'b0;

    function automatic void flag_error(input string msg);
        if (fail_count < 10) begin
            $display("%s", msg);
        end
        fail_count++;
    endfunction

    function automatic logic [BYTE_W-1:0] paeth_choice(input logic [BYTE_W-1:0] a,
                                                       input logic [BYTE_W-1:0] b,
                                                       input logic [BYTE_W-1:0] c);
        int p;
        int da;
        int db;
        int dc;
        p  = int'(a) + int'(b) - int'(c);
        da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
        db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
        dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
        if (da <= db && da <= dc) begin
            return a;
        end else if (db <= dc) begin
            return b;
        end
        return c;
    endfunction

    // Advances the predictor by one input byte; got is set when a result byte follows.
    function automatic void unfilter_step(input logic [BYTE_W-1:0] x, input logic st,
                                          output bit got, output t_pixel_out res);
        int unsigned       rb;
        int unsigned       bpp;
        int unsigned       col;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] y;
        bit                last;
        got = 1'b0;
        res = '0;
        if (st || want_filter) begin
            if (st) begin
                first_row = 1'b1;
            end
            filt_type   = x;
            col_pos     = 0;
            want_filter = 1'b0;
            return;
        end
        rb  = (rb_reg == 0) ? 1 : (rb_reg > MAX_ROW_BYTES) ? MAX_ROW_BYTES : rb_reg;
        bpp = (bpp_reg == 0) ? 1 : (bpp_reg > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : bpp_reg;
        col = (col_pos >= MAX_ROW_BYTES) ? MAX_ROW_BYTES - 1 : col_pos;
        b = first_row ? '0 : prev_row[col];
        a = '0;
        c = '0;
        if (col >= bpp) begin
            a = left_hist[(col - bpp) % HIST_DEPTH];
            if (!first_row) begin
                c = ul_hist[(col - bpp) % HIST_DEPTH];
            end
        end
        case (filt_type)
            FILT_NONE:  y = x;
            FILT_SUB:   y = x + a;
            FILT_UP:    y = x + b;
            FILT_AVG:   y = x + BYTE_W'((int'(a) + int'(b)) >> 1);
            FILT_PAETH: y = x + paeth_choice(a, b, c);
            default:    y = x;
        endcase
        ul_hist[col % HIST_DEPTH]   = b;
        left_hist[col % HIST_DEPTH] = y;
        prev_row[col] = y;
        prev_set[col] = 1'b1;
        last = (col + 1 >= rb);
        if (last) begin
            col_pos     = 0;
            want_filter = 1'b1;
            first_row   = 1'b0;
        end else begin
            col_pos = col + 1;
        end
        res = '{pixel: y, row_end: last, bad_filter: (filt_type > FILT_PAETH)};
        got = 1'b1;
    endfunction

    task automatic push_item(input logic [BYTE_W-1:0] dat, input logic st,
                             input logic typed, input t_pixel_out want);
        bit         got;
        t_pixel_out res;
        while (!steady && $urandom_range(99) < 23) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= dat;
        in_ch.image_start <= st;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        unfilter_step(dat, st, got, res);
        if (got) begin
            pending_bytes.push_back(typed ? want : res);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        // A trailing filter byte gives no result but may still be in the pipeline.
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        if (idx == REG_ROW_BYTES) begin
            rb_reg = val;
        end else if (idx == REG_BPP) begin
            bpp_reg = val[BPP_W-1:0];
        end
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed rows with random content; unless clean, also stray image starts and noise.
    task automatic run_phase(input int n_items, input bit clean);
        logic [BYTE_W-1:0] dat;
        logic              st;
        int                pick;
        int unsigned       col;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (!clean && pick < 3) begin
                dat = BYTE_W'($urandom);
                st  = 1'($urandom_range(1));
            end else if (want_filter || (clean && k == 0)) begin
                dat = (clean || pick < 88) ? BYTE_W'($urandom_range(FILT_PAETH))
                                           : BYTE_W'($urandom);
                st  = clean ? (k == 0) : ($urandom_range(7) == 0);
            end else begin
                dat = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                               : BYTE_W'($urandom);
                st  = !clean && pick < 5;
            end
            // Never read a previous-row entry that has not been written yet.
            col = (col_pos >= MAX_ROW_BYTES) ? MAX_ROW_BYTES - 1 : col_pos;
            if (!st && !want_filter && !first_row && !prev_set[col]) begin
                st = 1'b1;
            end
            push_item(dat, st, 1'b0, '0);
            random_sent++;
        end
    endtask

    // Result checking and receiver back-pressure.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_bytes.size() == 0) begin
                    flag_error($sformatf("unexpected result: byte %h end %b bad %b",
                                         out_ch.out_byte, out_ch.row_end, out_ch.bad_filter));
                end else if (pending_bytes[0] !== {out_ch.out_byte, out_ch.row_end,
                                                   out_ch.bad_filter}) begin
                    flag_error($sformatf(
                        "mismatch: expected byte %h end %b bad %b, got byte %h end %b bad %b",
                        pending_bytes[0].pixel, pending_bytes[0].row_end,
                        pending_bytes[0].bad_filter, out_ch.out_byte, out_ch.row_end,
                        out_ch.bad_filter));
                    void'(pending_bytes.pop_front());
                end else begin
                    void'(pending_bytes.pop_front());
                end
            end
            if (hold_req && !hold_done) begin
                hold_left = STALL_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAIL png_scanline_unfilter_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase;
        int n_items;
        logic [CFG_DATA_W-1:0] rb_pick;
        int pick;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.in_byte     <= '0;
        in_ch.image_start <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_ROW_BYTES;
        cfg_ch.data       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].is_cfg) begin
                drain();
                write_reg(PLAN[i].idx, PLAN[i].val);
            end else begin
                push_item(PLAN[i].dat, PLAN[i].st, PLAN[i].typed, PLAN[i].want);
            end
        end

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            drain();
            pick = $urandom_range(99);
            if (phase == 4) begin
                rb_pick = 13'd8191;
            end else if (pick < 10) begin
                rb_pick = 13'd0;
            end else if (pick < 20) begin
                rb_pick = 13'd1;
            end else if (pick < 25) begin
                rb_pick = CFG_DATA_W'($urandom_range(100, 300));
            end else begin
                rb_pick = CFG_DATA_W'($urandom_range(2, 24));
            end
            write_reg(REG_ROW_BYTES, rb_pick);
            write_reg(REG_BPP, CFG_DATA_W'($urandom_range(15)));
            steady   <= (phase == 2);
            hold_req <= (phase == 1);
            if (phase == 4) begin
                // A clean new image with the row length above the largest size.
                run_phase($urandom_range(40, 120), 1'b1);
            end else begin
                n_items = (phase == 2) ? 200 : $urandom_range(40, 120);
                run_phase(n_items, 1'b0);
            end
            phase++;
        end

        drain();
        if (fail_count == 0) begin
            $display("PASS png_scanline_unfilter_top");
        end else begin
            $display("FAIL png_scanline_unfilter_top");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/psu_pkg.sv
hw/rtl/psu_channels.sv
hw/rtl/psu_ram.sv
hw/rtl/psu_front.sv
hw/rtl/psu_fifo.sv
hw/rtl/psu_back.sv
hw/rtl/png_scanline_unfilter_top.sv
sim/png_scanline_unfilter_top_tb.sv
